@@ rtl/lrupr_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// lrupr_pkg: shared types and constants for the LRU page replacement unit
// Token and update structs carried along the frame cell chain, FSM states.
// ============================================================================
package lrupr_pkg;

   // Defaults for the top level parameters
   localparam int FRAMES_DEF    = 8;
   localparam int PAGE_BITS_DEF = 16;

   // Ceilings of the parameter ranges; the chain structs are sized to them
   localparam int MAX_IDX_BITS  = 6;   // FRAMES up to 64
   localparam int MAX_PAGE_BITS = 32;  // PAGE_BITS up to 32

   // Fixed field widths
   localparam int CSR_W      = 4;
   localparam logic [CSR_W-1:0] CSR_RESET = 4'd8;
   localparam int OUT_IDX_W  = 3;
   localparam int OUT_PAGE_W = 16;
   localparam int FAULT_W    = 32;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_UPDATE
   } state_type;

   // Search token: walks the chain one cell per cycle, collecting results
   typedef struct packed {
      logic                     valid;
      logic [MAX_PAGE_BITS-1:0] page;
      logic                     found;
      logic [MAX_IDX_BITS-1:0]  found_idx;
      logic [MAX_IDX_BITS-1:0]  found_rank;
      logic                     empty;
      logic [MAX_IDX_BITS-1:0]  empty_idx;
      logic [MAX_IDX_BITS-1:0]  vict_idx;
      logic [MAX_IDX_BITS-1:0]  vict_rank;
      logic [MAX_PAGE_BITS-1:0] vict_page;
   } tok_type;

   // Update command broadcast to all cells once the search is done
   typedef struct packed {
      logic                     valid;
      logic [MAX_IDX_BITS-1:0]  sel;
      logic [MAX_IDX_BITS-1:0]  pivot;
      logic                     age_all;
      logic                     write_page;
      logic                     set_valid;
      logic [MAX_PAGE_BITS-1:0] page;
   } upd_type;

endpackage

@@ rtl/lrupr_cell.sv @@
`timescale 1ns / 1ps
// ============================================================================
// lrupr_cell: one frame of the replacement chain
// Holds page, valid and recency rank; folds itself into the passing search
// token and applies the broadcast update.
// ============================================================================
module lrupr_cell #(
   parameter int IDX       = 0,
   parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
   parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              active,
   input  lrupr_pkg::tok_type tok_in,
   output lrupr_pkg::tok_type tok_out,
   input  lrupr_pkg::upd_type upd
);

   localparam int RANK_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(FRAMES - 1);
   localparam logic [lrupr_pkg::MAX_IDX_BITS-1:0] MY_IDX =
      lrupr_pkg::MAX_IDX_BITS'(IDX);

   logic [PAGE_BITS-1:0] page_ff;
   logic                 valid_ff;
   logic [RANK_W-1:0]    rank_ff;
   logic [RANK_W-1:0]    rank_in;
   logic                 valid_in;
   logic [lrupr_pkg::MAX_IDX_BITS-1:0] rank_ext;
   lrupr_pkg::tok_type   tok_ff;
   lrupr_pkg::tok_type   tok_in_nxt;

   assign rank_ext = lrupr_pkg::MAX_IDX_BITS'(rank_ff);
   assign tok_out  = tok_ff;

   // search fold
   always_comb begin
      tok_in_nxt = tok_in;
      if (tok_in.valid && active) begin
         if (!tok_in.found && valid_ff && page_ff == tok_in.page[PAGE_BITS-1:0]) begin
            tok_in_nxt.found      = 1'b1;
            tok_in_nxt.found_idx  = MY_IDX;
            tok_in_nxt.found_rank = rank_ext;
         end
         if (!tok_in.empty && !valid_ff) begin
            tok_in_nxt.empty     = 1'b1;
            tok_in_nxt.empty_idx = MY_IDX;
         end
         // oldest wins; ties keep the lower index
         if (IDX == 0 || rank_ext > tok_in.vict_rank) begin
            tok_in_nxt.vict_idx  = MY_IDX;
            tok_in_nxt.vict_rank = rank_ext;
            tok_in_nxt.vict_page = lrupr_pkg::MAX_PAGE_BITS'(page_ff);
         end
      end
   end

   // update
   always_comb begin
      rank_in  = rank_ff;
      valid_in = valid_ff;
      if (upd.valid && active) begin
         if (upd.sel == MY_IDX) begin
            rank_in = '0;
            if (upd.set_valid) begin
               valid_in = 1'b1;
            end
         end else if (valid_ff && (upd.age_all || rank_ext < upd.pivot) &&
                      rank_ff != RANK_MAX) begin
            rank_in = rank_ff + RANK_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff   <= '0;
         valid_ff <= 1'b0;
         rank_ff  <= '0;
      end else begin
         tok_ff   <= tok_in_nxt;
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      if (upd.valid && active && upd.sel == MY_IDX && upd.write_page) begin
         page_ff <= upd.page[PAGE_BITS-1:0];
      end
   end

endmodule

@@ rtl/lrupr_ctrl.sv @@
`timescale 1ns / 1ps
// ============================================================================
// lrupr_ctrl: sequencer of the LRU page replacement unit
// Injects the search token, picks hit / fill / evict from the chain tail,
// broadcasts the update and presents the result.
// ============================================================================
module lrupr_ctrl #(
   parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [PAGE_BITS-1:0]               req_page,
   input  logic                               req_last_reference,
   output lrupr_pkg::tok_type                 tok_inj,
   input  lrupr_pkg::tok_type                 tok_tail,
   output lrupr_pkg::upd_type                 upd,
   output logic                               rsp_valid,
   output logic                               rsp_hit,
   output logic [lrupr_pkg::OUT_IDX_W-1:0]    rsp_frame_index,
   output logic                               rsp_evicted_valid,
   output logic [lrupr_pkg::OUT_PAGE_W-1:0]   rsp_evicted_page,
   output logic [lrupr_pkg::FAULT_W-1:0]      rsp_fault_count,
   output logic                               rsp_end_of_string
);

   lrupr_pkg::state_type state_ff, state_in;
   logic                 accept;
   logic                 decide;

   logic [PAGE_BITS-1:0]              page_ff;
   logic                              last_ff;
   logic [lrupr_pkg::FAULT_W-1:0]     fault_ff, fault_in;
   lrupr_pkg::upd_type                upd_ff, upd_in;
   logic                              hit_ff, hit_in;
   logic                              ev_valid_ff, ev_valid_in;
   logic [lrupr_pkg::OUT_PAGE_W-1:0]  ev_page_ff, ev_page_in;

   assign busy   = (state_ff != lrupr_pkg::ST_IDLE);
   assign accept = start && !busy;
   assign decide = (state_ff == lrupr_pkg::ST_SEARCH) && tok_tail.valid;

   always_comb begin
      tok_inj       = '0;
      tok_inj.valid = accept;
      tok_inj.page  = lrupr_pkg::MAX_PAGE_BITS'(req_page);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lrupr_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = lrupr_pkg::ST_SEARCH;
            end
         end
         lrupr_pkg::ST_SEARCH: begin
            if (tok_tail.valid) begin
               state_in = lrupr_pkg::ST_UPDATE;
            end
         end
         lrupr_pkg::ST_UPDATE: state_in = lrupr_pkg::ST_IDLE;
         default:              state_in = lrupr_pkg::ST_IDLE;
      endcase
   end

   // hit, fill of the first empty frame, or eviction of the oldest
   always_comb begin
      upd_in      = '0;
      upd_in.page = lrupr_pkg::MAX_PAGE_BITS'(page_ff);
      hit_in      = 1'b0;
      ev_valid_in = 1'b0;
      ev_page_in  = '0;
      fault_in    = fault_ff;
      priority if (tok_tail.found) begin
         hit_in       = 1'b1;
         upd_in.sel   = tok_tail.found_idx;
         upd_in.pivot = tok_tail.found_rank;
      end else if (tok_tail.empty) begin
         upd_in.sel        = tok_tail.empty_idx;
         upd_in.age_all    = 1'b1;
         upd_in.write_page = 1'b1;
         upd_in.set_valid  = 1'b1;
         fault_in          = fault_ff + lrupr_pkg::FAULT_W'(1);
      end else begin
         upd_in.sel        = tok_tail.vict_idx;
         upd_in.pivot      = tok_tail.vict_rank;
         upd_in.write_page = 1'b1;
         ev_valid_in       = 1'b1;
         ev_page_in        = lrupr_pkg::OUT_PAGE_W'(tok_tail.vict_page);
         fault_in          = fault_ff + lrupr_pkg::FAULT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lrupr_pkg::ST_IDLE;
         fault_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (decide) begin
            fault_ff <= fault_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         page_ff <= req_page;
         last_ff <= req_last_reference;
      end
      if (decide) begin
         upd_ff      <= upd_in;
         hit_ff      <= hit_in;
         ev_valid_ff <= ev_valid_in;
         ev_page_ff  <= ev_page_in;
      end
   end

   always_comb begin
      upd       = upd_ff;
      upd.valid = (state_ff == lrupr_pkg::ST_UPDATE);
   end

   assign rsp_valid         = (state_ff == lrupr_pkg::ST_UPDATE);
   assign rsp_hit           = hit_ff;
   assign rsp_frame_index   = lrupr_pkg::OUT_IDX_W'(upd_ff.sel);
   assign rsp_evicted_valid = ev_valid_ff;
   assign rsp_evicted_page  = ev_page_ff;
   assign rsp_fault_count   = fault_ff;
   assign rsp_end_of_string = last_ff;

   // token leaves the chain only while a search is pending
   a_tail_in_search: assert property (@(posedge clock) disable iff (reset)
      tok_tail.valid |-> state_ff == lrupr_pkg::ST_SEARCH)
      else $error("search token at chain tail outside search");

   // fault total moves by one on each miss and never otherwise
   a_fault_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == lrupr_pkg::ST_UPDATE |->
         fault_ff == $past(fault_ff) + lrupr_pkg::FAULT_W'(!hit_ff))
      else $error("fault total out of step with hit");

   // an eviction is always a miss
   a_evict_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evicted_valid |-> !rsp_hit)
      else $error("eviction reported on a hit");

   // no new item while the chain holds one
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      tok_inj.valid |-> state_ff == lrupr_pkg::ST_IDLE && !upd.valid)
      else $error("token injected while busy");

endmodule

@@ rtl/lru_page_replacement_unit.sv @@
`timescale 1ns / 1ps
// ============================================================================
// lru_page_replacement_unit: fully associative LRU page replacement
// Chain of frame cells searched by a travelling token, then updated by one
// broadcast; reports hit, frame, evicted page and running fault total.
// ============================================================================
//
// Channel   Direction  Handshake                   Payload
// req_      in         start & !busy               page, last_reference
// rsp_      out        rsp_valid, one-cycle strobe hit, frame_index, evicted_*,
//                                                  fault_count, end_of_string
// csr_      in         csr_wr_en                   frames_in_use (4 bits)
//
// Sequence: the search token steps through one frame cell per cycle; the
//   decision is then registered, and the update is applied while the
//   result is strobed.
// busy is high from the cycle after acceptance until the result cycle ends.
// Reset (synchronous): all frames empty, ranks zero, fault total zero,
//   frames_in_use = 8.
// The receiver cannot stall: each result is shown for exactly one cycle.
//
module lru_page_replacement_unit #(
   parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
   parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // item request
   input  logic                               start,
   output logic                               busy,
   input  logic [PAGE_BITS-1:0]               req_page,
   input  logic                               req_last_reference,
   // result
   output logic                               rsp_valid,
   output logic                               rsp_hit,
   output logic [lrupr_pkg::OUT_IDX_W-1:0]    rsp_frame_index,
   output logic                               rsp_evicted_valid,
   output logic [lrupr_pkg::OUT_PAGE_W-1:0]   rsp_evicted_page,
   output logic [lrupr_pkg::FAULT_W-1:0]      rsp_fault_count,
   output logic                               rsp_end_of_string,
   // frames_in_use register
   input  logic                               csr_wr_en,
   input  logic [lrupr_pkg::CSR_W-1:0]        csr_wr_data
);

   localparam int CNT_W = $clog2(FRAMES + 1);

   logic [lrupr_pkg::CSR_W-1:0] csr_ff;
   logic [CNT_W-1:0]            n_eff;     // frames taking part, clamped
   logic [FRAMES-1:0]           active;
   lrupr_pkg::tok_type          link [FRAMES+1];
   lrupr_pkg::upd_type          upd;

   // frames_in_use register; written only while idle (a rule for the user; the block does not enforce it)
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= lrupr_pkg::CSR_RESET;
      end else if (csr_wr_en) begin
         csr_ff <= csr_wr_data;
      end
   end

   // zero acts as one, anything above FRAMES acts as FRAMES
   always_comb begin
      priority if (csr_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (32'(csr_ff) > 32'(FRAMES)) begin
         n_eff = CNT_W'(FRAMES);
      end else begin
         n_eff = CNT_W'(csr_ff);
      end
   end

   // frame cells: link[g] enters cell g, link[g+1] leaves it
   for (genvar g = 0; g < FRAMES; g++) begin : g_cell
      assign active[g] = (32'(g) < 32'(n_eff));

      lrupr_cell #(
         .IDX       (g),
         .FRAMES    (FRAMES),
         .PAGE_BITS (PAGE_BITS)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .active  (active[g]),
         .tok_in  (link[g]),
         .tok_out (link[g+1]),
         .upd     (upd)
      );
   end

   lrupr_ctrl #(
      .PAGE_BITS (PAGE_BITS)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_page           (req_page),
      .req_last_reference (req_last_reference),
      .tok_inj            (link[0]),
      .tok_tail           (link[FRAMES]),
      .upd                (upd),
      .rsp_valid          (rsp_valid),
      .rsp_hit            (rsp_hit),
      .rsp_frame_index    (rsp_frame_index),
      .rsp_evicted_valid  (rsp_evicted_valid),
      .rsp_evicted_page   (rsp_evicted_page),
      .rsp_fault_count    (rsp_fault_count),
      .rsp_end_of_string  (rsp_end_of_string)
   );

endmodule
